[sv/rlt_pkg.sv]
package rlt_pkg;

   localparam int DEF_ENTRIES = 32;
   localparam int DEF_KEY_BITS = 32;

   localparam int KEY_PORT_BITS = 32;
   localparam int OWNER_BITS = 32;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [OWNER_BITS-1:0] OWNER_NONE = '0;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BUSY = 2'd1,
      STATUS_NONE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic pick;
      logic decide;
   } ctrl_cmd_type;

endpackage

[sv/rlt_ram.sv]
module rlt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rlt_ctrl.sv]
module rlt_ctrl
   import rlt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      priority if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/rlt_dp.sv]
module rlt_dp
   import rlt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   input  logic                     req_type,
   input  logic [KEY_PORT_BITS-1:0] req_resource_key,
   input  logic [OWNER_BITS-1:0]    req_owner_id,
   output logic [1:0]               rsp_status
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   function automatic logic [IDX_BITS-1:0] first_set(input logic [ENTRIES-1:0] vec);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_BITS'(i);
         end
      end
      return idx;
   endfunction

   logic [KEY_BITS-1:0]   key_in;
   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_arr_ff [ENTRIES];
   logic                  type_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [ENTRIES-1:0]    match_ff;
   logic [ENTRIES-1:0]    free_ff;
   logic                  hit_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff;
   logic                  empty_ff;
   logic [IDX_BITS-1:0]   empty_idx_ff;
   status_type            status_ff;
   status_type            status_in;
   logic [IDX_BITS-1:0]   hit_idx_in;
   logic [OWNER_BITS-1:0] owner_rd;
   logic                  owner_we;
   logic [IDX_BITS-1:0]   owner_waddr;
   logic [OWNER_BITS-1:0] owner_wdata;
   logic                  claim;

   generate
      if (KEY_BITS <= KEY_PORT_BITS) begin : g_key_trunc
         assign key_in = req_resource_key[KEY_BITS-1:0];
      end else begin : g_key_ext
         assign key_in = {{(KEY_BITS - KEY_PORT_BITS){1'b0}}, req_resource_key};
      end
   endgenerate

   assign hit_idx_in = first_set(match_ff);

   rlt_ram #(
      .WIDTH (OWNER_BITS),
      .DEPTH (ENTRIES)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we),
      .wr_addr (owner_waddr),
      .wr_data (owner_wdata),
      .rd_en   (cmd.pick),
      .rd_addr (hit_idx_in),
      .rd_data (owner_rd)
   );

   always_comb begin
      status_in   = STATUS_NONE;
      owner_we    = 1'b0;
      owner_waddr = hit_idx_ff;
      owner_wdata = owner_ff;
      claim       = 1'b0;
      if (type_ff == REQ_ACQUIRE) begin
         if (hit_ff) begin
            if (owner_rd == OWNER_NONE) begin
               owner_we  = cmd.decide;
               status_in = STATUS_OK;
            end else begin
               status_in = STATUS_BUSY;
            end
         end else if (empty_ff) begin
            owner_we    = cmd.decide;
            owner_waddr = empty_idx_ff;
            claim       = cmd.decide;
            status_in   = STATUS_OK;
         end
      end else if (hit_ff) begin
         if (owner_rd == owner_ff) begin
            owner_we    = cmd.decide;
            owner_wdata = OWNER_NONE;
            status_in   = STATUS_OK;
         end else begin
            status_in = STATUS_BUSY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (claim) begin
         valid_ff[empty_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (claim) begin
         key_arr_ff[empty_idx_ff] <= key_ff;
      end
      if (cmd.capture) begin
         type_ff  <= req_type;
         key_ff   <= key_in;
         owner_ff <= req_owner_id;
         free_ff  <= ~valid_ff;
         for (int i = 0; i < ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (key_arr_ff[i] == key_in);
         end
      end
      if (cmd.pick) begin
         hit_ff       <= |match_ff;
         hit_idx_ff   <= hit_idx_in;
         empty_ff     <= |free_ff;
         empty_idx_ff <= first_set(free_ff);
      end
      if (cmd.decide) begin
         status_ff <= status_in;
      end
   end

   assign rsp_status = status_ff;

endmodule

[sv/resource_lock_table_unit.sv]
// A request is captured with its key compare on the edge that accepts it; the
// first-match and first-free pick and the owner RAM read follow, then the update,
// which registers the status. No new request is taken until the update is done.
// Reset clears the valid marks and the control state; keys and owners are
// not cleared and are only read for valid entries.
module resource_lock_table_unit
   import rlt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [KEY_PORT_BITS-1:0] req_resource_key,
   input  logic [OWNER_BITS-1:0]    req_owner_id,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status
);

   ctrl_cmd_type cmd;

   rlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rlt_dp #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_resource_key (req_resource_key),
      .req_owner_id     (req_owner_id),
      .rsp_status       (rsp_status)
   );

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.pick, cmd.decide}))
      else $error("more than one datapath command at once");

   a_accept_pick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (cmd.pick && req_stall))
      else $error("accepted transfer did not move on to the pick step");

   a_decide_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_valid)
      else $error("update did not present a result");

endmodule
